/* hw/rtl/sha256_counter_mode_prg_defines.svh */
// assertion macros for the keystream generator
`ifndef SHA256_COUNTER_MODE_PRG_DEFINES_SVH
`define SHA256_COUNTER_MODE_PRG_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SCP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`else
`define SCP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/scmp_pkg.sv */
package scmp_pkg;
   localparam int MaxRequestBytes = 32;
   localparam int BlockBytes = 32;
   localparam logic [63:0] MsgBits = 64'd320;
   localparam int CsrAddrWidth = 5;
   localparam logic [CsrAddrWidth-1:0] AddrKey0 = 5'd0;
   localparam logic [CsrAddrWidth-1:0] AddrKey1 = 5'd8;
   localparam logic [CsrAddrWidth-1:0] AddrKey2 = 5'd16;
   localparam logic [CsrAddrWidth-1:0] AddrKey3 = 5'd24;
   localparam logic ModeProduce = 1'b0;
   localparam logic ModeRestart = 1'b1;

   typedef struct packed {
      logic start;
      logic done;
   } hash_ctl_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [255:0] init_h();
      return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   endfunction
endpackage

/* hw/rtl/scmp_round.sv */
module scmp_round
   import scmp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hash_ctl_type ctl_in,
   input  logic [511:0] msg_in,
   output logic         busy_out,
   output hash_ctl_type status_out,
   output logic [255:0] digest_out
);
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [5:0]   round_ff, round_in;
   logic [511:0] w_ff, w_in;
   logic [255:0] st_ff, st_in;
   logic [255:0] dig_ff, dig_in;
   logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, s0, s1, ws0, ws1, wnew;
   logic [255:0] hi;

   // unpack working state and schedule terms
   always_comb begin
      {a, b, c, d, e, f, g, h} = st_ff;
      s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
      s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
      t1 = h + s1 + ((e & f) ^ (~e & g)) + round_k(round_ff) + w_ff[511:480];
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      ws0 = {w_ff[454:448], w_ff[479:455]} ^ {w_ff[465:448], w_ff[479:466]}
            ^ {3'b000, w_ff[479:451]};
      ws1 = {w_ff[48:32], w_ff[63:49]} ^ {w_ff[50:32], w_ff[63:51]}
            ^ {10'b0, w_ff[63:42]};
      wnew = w_ff[511:480] + ws0 + w_ff[223:192] + ws1;
      hi = init_h();
   end

   // one round per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      round_in = round_ff;
      w_in = w_ff;
      st_in = st_ff;
      dig_in = dig_ff;
      if (ctl_in.start && !busy_ff) begin
         busy_in = 1'b1;
         round_in = '0;
         w_in = msg_in;
         st_in = hi;
      end else if (busy_ff) begin
         st_in = {t1 + t2, a, b, c, d + t1, e, f, g};
         w_in = {w_ff[479:0], wnew};
         round_in = round_ff + 6'd1;
         if (round_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            dig_in = {hi[255:224] + t1 + t2, hi[223:192] + a, hi[191:160] + b,
                      hi[159:128] + c, hi[127:96] + d + t1, hi[95:64] + e,
                      hi[63:32] + f, hi[31:0] + g};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      round_ff <= round_in;
      w_ff <= w_in;
      st_ff <= st_in;
      dig_ff <= dig_in;
   end

   assign busy_out = busy_ff;
   assign status_out = '{start: 1'b0, done: done_ff};
   assign digest_out = dig_ff;
endmodule

/* hw/rtl/sha256_counter_mode_prg.sv */
// channel | ports          | content
// request | req_t*         | tdata: mode, byte_count
// result  | rsp_t*         | tdata: data_byte; tlast: last_byte
// config  | csr_p*         | four 64-bit key registers at 8*i
// a request emits its bytes from the cached digest; when the cache is used up,
// a fresh block is launched into the one-round-per-cycle unit and its digest cached
// a restart or zero request is taken without leaving idle; reset clears the counter and marks the cache used up
// a stalled result holds the sequencer; no request is taken while busy
`include "sha256_counter_mode_prg_defines.svh"
module sha256_counter_mode_prg
   import scmp_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = MaxRequestBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // mode, byte_count[6:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // data_byte
   output logic        rsp_tlast,   // last_byte
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   localparam int CntW = $clog2(MAX_REQUEST_BYTES + 1);

   typedef enum logic [3:0] {
      StIdle = 4'b0001, StHash = 4'b0010, StEmit = 4'b0100, StWait = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [63:0]  key_ff [4];
   logic [63:0]  ctr_ff, ctr_in;
   logic [5:0]   used_ff, used_in;
   logic [CntW-1:0] left_ff, left_in;
   logic [255:0] cache_ff, cache_in;
   logic [7:0]   byte_ff, byte_in;
   logic         last_ff, last_in;
   logic         vld_ff, vld_in;
   hash_ctl_type hctl, hstat;
   logic         hbusy;
   logic [255:0] digest;
   logic [511:0] msg;
   logic [5:0]   req_cnt;
   logic         csr_wr;
   logic [63:0]  ctr_le;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_wr) begin
         case (csr_paddr)
            AddrKey0: key_ff[0] <= csr_pwdata;
            AddrKey1: key_ff[1] <= csr_pwdata;
            AddrKey2: key_ff[2] <= csr_pwdata;
            AddrKey3: key_ff[3] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr)
         AddrKey0: csr_prdata = key_ff[0];
         AddrKey1: csr_prdata = key_ff[1];
         AddrKey2: csr_prdata = key_ff[2];
         AddrKey3: csr_prdata = key_ff[3];
         default: csr_prdata = '0;
      endcase
   end

   // padded message block
   always_comb begin
      for (int i = 0; i < 8; i++) ctr_le[63-8*i -: 8] = ctr_ff[8*i +: 8];
      msg = {key_ff[0], key_ff[1], key_ff[2], key_ff[3], ctr_le, 8'h80,
             120'b0, MsgBits};
   end

   scmp_round u_round (
      .clock(clock), .reset(reset), .ctl_in(hctl), .msg_in(msg),
      .busy_out(hbusy), .status_out(hstat), .digest_out(digest)
   );

   assign req_cnt = req_tdata[6:1];
   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = byte_ff;
   assign rsp_tlast = last_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      ctr_in = ctr_ff;
      used_in = used_ff;
      left_in = left_ff;
      cache_in = cache_ff;
      byte_in = byte_ff;
      last_in = last_ff;
      vld_in = vld_ff;
      hctl = '{start: 1'b0, done: 1'b0};
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               if (req_tdata[0] == ModeRestart) begin
                  ctr_in = '0;
                  used_in = 6'(BlockBytes);
               end else if (req_cnt != 6'd0) begin
                  left_in = (32'(req_cnt) > MAX_REQUEST_BYTES) ?
                     CntW'(MAX_REQUEST_BYTES) : CntW'(req_cnt);
                  state_in = StEmit;
               end
            end
         end
         StEmit: begin
            if (!vld_ff || rsp_tready) begin
               if (used_ff[5]) begin
                  hctl.start = 1'b1;
                  state_in = StHash;
               end else begin
                  byte_in = cache_ff[255 - 8*used_ff[4:0] -: 8];
                  last_in = (left_ff == CntW'(1));
                  vld_in = 1'b1;
                  used_in = used_ff + 6'd1;
                  left_in = left_ff - CntW'(1);
                  if (left_ff == CntW'(1)) state_in = StWait;
               end
            end
         end
         StHash: begin
            if (hstat.done) begin
               cache_in = digest;
               ctr_in = ctr_ff + 64'd1;
               used_in = '0;
               state_in = StEmit;
            end
         end
         StWait: begin
            if (!vld_ff || rsp_tready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         ctr_ff <= '0;
         used_ff <= 6'(BlockBytes);
         vld_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         state_ff <= state_in;
         ctr_ff <= ctr_in;
         used_ff <= used_in;
         vld_ff <= vld_in;
         left_ff <= left_in;
      end
      cache_ff <= cache_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   // checks
   `SCP_ASSERT_IMPL(a_no_req_busy, clock, reset, hbusy, !req_tready)
   `SCP_ASSERT_IMPL(a_used_range, clock, reset, 1'b1, used_ff <= 6'(BlockBytes))
   `SCP_ASSERT_NEXT(a_done_emit, clock, reset, hstat.done, state_ff == StEmit)
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import scmp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // mode, byte_count
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // data_byte
   logic        rsp_tlast;         // last_byte
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   sha256_counter_mode_prg u_dut (.*);

   always #5 clock = ~clock;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } keystream_byte_type;

   // shadow state of the generator
   logic [63:0]  key_shadow [4];
   logic [63:0]  counter_shadow;
   logic [255:0] digest_shadow;
   int unsigned  used_shadow;

   logic [7:0]         request_q [$];
   keystream_byte_type keystream_q [$];
   int unsigned        send_idle_pct = 0;
   int unsigned        recv_idle_pct = 0;
   int unsigned        quiet_cycles = 0;
   bit                 failed = 1'b0;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // sha-256 of key plus little-endian counter, one padded message block
   function automatic logic [255:0] keystream_block(input logic [63:0] cnt);
      logic [31:0] w [64];
      logic [31:0] hv [8];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      logic [31:0] kc [64];
      logic [511:0] msg;
      logic [255:0] res;
      kc = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
             32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
             32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
             32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
             32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
             32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
             32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
             32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
             32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
             32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
             32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
             32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
             32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      hv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      msg = {key_shadow[0], key_shadow[1], key_shadow[2], key_shadow[3],
             {<<8{cnt}}, 8'h80, 120'd0, 64'd320};
      for (int i = 0; i < 16; i++) w[i] = msg[511 - 32*i -: 32];
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      {a, b, c, d, e, f, g, h} = {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + kc[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      res = {hv[0] + a, hv[1] + b, hv[2] + c, hv[3] + d,
             hv[4] + e, hv[5] + f, hv[6] + g, hv[7] + h};
      return res;
   endfunction

   // expected bytes for one accepted request
   function automatic void predict_keystream(input logic [7:0] req);
      int unsigned n;
      keystream_byte_type kb;
      if (req[0] == ModeRestart) begin
         counter_shadow = '0;
         used_shadow = BlockBytes;
         return;
      end
      n = req[6:1];
      if (n > MaxRequestBytes) n = MaxRequestBytes;
      for (int k = 0; k < n; k++) begin
         if (used_shadow >= BlockBytes) begin
            digest_shadow = keystream_block(counter_shadow);
            counter_shadow = counter_shadow + 64'd1;
            used_shadow = 0;
         end
         kb.data_byte = digest_shadow[255 - 8*used_shadow -: 8];
         kb.last_byte = (k + 1 == n);
         keystream_q.push_back(kb);
         used_shadow++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= request_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result ready and request acceptance
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_tvalid && req_tready) predict_keystream(req_tdata);
      end
   end

   // result monitor and watchdog
   always @(posedge clock) begin
      keystream_byte_type exp_b;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("sha256_counter_mode_prg regression: fail");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (keystream_q.size() == 0) begin
               $display("%0t unexpected transfer data %h last %b", $time, rsp_tdata, rsp_tlast);
               failed = 1'b1;
            end else begin
               exp_b = keystream_q.pop_front();
               if (exp_b.data_byte !== rsp_tdata || exp_b.last_byte !== rsp_tlast) begin
                  $display("%0t mismatch expected %h/%b actual %h/%b", $time,
                           exp_b.data_byte, exp_b.last_byte, rsp_tdata, rsp_tlast);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   task automatic write_key(input int idx, input logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CsrAddrWidth'(8 * idx); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      key_shadow[idx] = val;
   endtask

   task automatic wait_drained();
      while (request_q.size() != 0 || req_tvalid || keystream_q.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [7:0] produce(input int n);
      return {1'b0, 6'(n), ModeProduce};
   endfunction

   initial begin
      logic [7:0] rq;
      foreach (key_shadow[i]) key_shadow[i] = '0;
      counter_shadow = '0;
      digest_shadow = '0;
      used_shadow = BlockBytes;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: zero key, extremes, restart, partial blocks, oversized sizes
      send_idle_pct = 27; recv_idle_pct = 70;
      request_q = '{produce(1), produce(0), produce(32), produce(31), produce(2),
                    produce(33), produce(63), {1'b1, 6'd63, ModeRestart},
                    produce(5), {1'b0, 6'd0, ModeRestart}, produce(32), produce(17),
                    produce(16), produce(40)};
      wait_drained();

      // all-ones key, key change mid-block
      for (int i = 0; i < 4; i++) write_key(i, 64'hffff_ffff_ffff_ffff);
      request_q = '{produce(3), produce(32)};
      wait_drained();
      write_key(2, 64'h0123_4567_89ab_cdef);
      request_q = '{produce(31), produce(1), produce(9)};
      wait_drained();

      // random phases with random keys
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 70 : 0;
         recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 27 : 0;
         for (int i = 0; i < 4; i++) write_key(i, {$urandom, $urandom});
         for (int j = 0; j < 28; j++) begin
            rq = $urandom;
            rq[7] = 1'b0;
            if ($urandom_range(9) != 0) rq[0] = ModeProduce;
            if ($urandom_range(3) != 0 && rq[0] == ModeProduce)
               rq[6:1] = $urandom_range(1, 32);
            request_q.push_back(rq);
         end
         wait_drained();
      end

      if (!failed) begin
         $display("sha256_counter_mode_prg regression: pass");
      end else begin
         $display("sha256_counter_mode_prg regression: fail");
      end
      $finish;
   end
endmodule

/* sha256_counter_mode_prg.f */
+incdir+hw/rtl
hw/rtl/scmp_pkg.sv
hw/rtl/scmp_round.sv
hw/rtl/sha256_counter_mode_prg.sv
tb/tb_top.sv
